/* rtl/gmr_pkg.sv */
// shared types, constants and state codes for the gmr parallel resistance accumulator
package gmr_pkg;

    localparam int unsigned MaxPairs = 1048576;
    localparam logic [20:0] CountCap = (MaxPairs < 21'h1FFFFF) ? 21'(MaxPairs) : 21'h1FFFFF;

    localparam logic [2:0] CfgGmr   = 3'd0;
    localparam logic [2:0] CfgRmin  = 3'd1;
    localparam logic [2:0] CfgLay1  = 3'd2;
    localparam logic [2:0] CfgLay2  = 3'd3;
    localparam logic [2:0] CfgCellX = 3'd4;
    localparam logic [2:0] CfgCellY = 3'd5;

    localparam logic [1:0] StOk     = 2'd0;
    localparam logic [1:0] StNoPair = 2'd1;
    localparam logic [1:0] StZeroV  = 2'd2;
    localparam logic [1:0] StNonPos = 2'd3;

    typedef struct packed {
        logic [7:0]         layer_a;
        logic [7:0]         layer_b;
        logic signed [31:0] offset_x;
        logic signed [31:0] offset_y;
        logic signed [23:0] mag_a_x;
        logic signed [23:0] mag_a_y;
        logic signed [23:0] mag_a_z;
        logic signed [23:0] mag_b_x;
        logic signed [23:0] mag_b_y;
        logic signed [23:0] mag_b_z;
        logic               last_pair;
    } t_in;

    typedef struct packed {
        logic [47:0] resistance;
        logic [20:0] pair_count;
        logic [1:0]  status;
    } t_out;

    typedef enum logic [4:0] {
        S_IDLE, S_MUL, S_SQA, S_SQB, S_PQ, S_DCOS, S_TERM, S_RM, S_RSUM,
        S_DG, S_ACC, S_FIN, S_DRES, S_OUT
    } t_state;

    typedef struct packed {
        logic        start;
        logic [6:0]  steps;
        logic [63:0] num;
        logic [63:0] den;
    } t_div_cmd;

endpackage

/* rtl/gmr_div.sv */
// restoring divider, one quotient bit per cycle, saturating 64-bit quotient
module gmr_div
    import gmr_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_div_cmd    i_cmd,
    output logic        o_busy,
    output logic [63:0] o_quot
);
    // numerator bits enter msb first, then zeros; steps = 64 + shift
    logic [127:0] r_num;
    logic [63:0]  r_rem, r_q, r_den;
    logic [6:0]   r_cnt;
    logic         r_ovf, r_busy;
    logic [64:0]  w_sh;
    logic         w_ge;

    always_comb begin
        w_sh = {r_rem, r_num[127]};
        w_ge = w_sh >= {1'b0, r_den};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
        end else if (i_cmd.start) begin
            r_busy <= 1'b1;
            r_cnt  <= i_cmd.steps;
            r_num  <= {i_cmd.num, 64'd0};
            r_den  <= i_cmd.den;
            r_rem  <= '0;
            r_q    <= '0;
            r_ovf  <= 1'b0;
        end else if (r_busy) begin
            r_num <= r_num << 1;
            r_rem <= w_ge ? 64'(w_sh - {1'b0, r_den}) : w_sh[63:0];
            if (r_q[63]) begin
                r_ovf <= 1'b1;
            end
            r_q   <= {r_q[62:0], w_ge};
            r_cnt <= r_cnt - 7'd1;
            if (r_cnt == 7'd1) begin
                r_busy <= 1'b0;
            end
        end
    end

    assign o_busy = r_busy;
    assign o_quot = r_ovf ? '1 : r_q;
endmodule

/* rtl/gmr_parallel_resistance_accumulator_unit.sv */
// Pair filter and conductance accumulator. A beat whose pair passes the layer
// and overlap tests and the pair-count cap runs through a sequencer around one
// 33x33 multiplier, a bit-serial square root and a shared one-bit-per-cycle
// divider: nine multiply steps, two square roots, a 110-step cosine division
// and a 120-step conductance division, cut short after the square roots for a
// zero magnitude or after the cosine for a non-positive change. A rejected
// pair skips the sequencer; a last-pair beat then adds a 120-step final division
// when it applies and hands over the result. Input stall stays high until the
// beat is fully done and its result, if any, taken.
module gmr_parallel_resistance_accumulator_unit
    import gmr_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  t_in         i_data,
    output logic        o_valid,
    input  logic        i_stall,
    output t_out        o_data,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_idx,
    input  logic [47:0] i_cfg_data
);
    logic [17:0] r_gmr;
    logic [47:0] r_rmin;
    logic [7:0]  r_lay1, r_lay2;
    logic [30:0] r_cx, r_cy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gmr <= '0; r_rmin <= 48'd65536; r_lay1 <= '0; r_lay2 <= 8'd1;
            r_cx <= '0; r_cy <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CfgGmr:   r_gmr  <= i_cfg_data[17:0];
                CfgRmin:  r_rmin <= i_cfg_data;
                CfgLay1:  r_lay1 <= i_cfg_data[7:0];
                CfgLay2:  r_lay2 <= i_cfg_data[7:0];
                CfgCellX: r_cx   <= i_cfg_data[30:0];
                CfgCellY: r_cy   <= i_cfg_data[30:0];
                default: ;
            endcase
        end
    end

    t_state      r_st, n_st;
    t_in         r_in;
    logic [63:0] r_sum;
    logic [20:0] r_cnt;
    logic [1:0]  r_err;
    t_out        r_out;
    // accumulators for products
    logic [3:0]   r_k;
    logic [49:0]  r_na, r_nb;
    logic signed [49:0] r_dot;
    logic [65:0]  r_sqx;
    logic [32:0]  r_sqr;
    logic [5:0]   r_sqi;
    logic [32:0]  r_qa;
    logic [63:0]  r_t;
    logic [63:0]  r_rr;

    // shared multiplier, 33x33 signed
    logic signed [32:0] w_ma, w_mb;
    logic signed [65:0] w_mp;
    assign w_mp = w_ma * w_mb;

    t_div_cmd    w_dcmd;
    logic        w_dbusy;
    logic [63:0] w_dq;
    gmr_div u_div (.i_clk(i_clk), .i_rst_n(i_rst_n), .i_cmd(w_dcmd),
                   .o_busy(w_dbusy), .o_quot(w_dq));

    logic [31:0] w_adx, w_ady;
    logic        w_keep;
    always_comb begin
        w_adx = i_data.offset_x[31] ? 32'(-i_data.offset_x) : i_data.offset_x;
        w_ady = i_data.offset_y[31] ? 32'(-i_data.offset_y) : i_data.offset_y;
        w_keep = i_data.layer_a == r_lay1 && i_data.layer_b == r_lay2 &&
                 w_adx < {1'b0, r_cx} && w_ady < {1'b0, r_cy} && r_cnt < CountCap;
    end

    // square-root step (restoring, two bits per step)
    logic [34:0] w_rem_n;
    logic [34:0] r_srem;
    logic [34:0] w_sub;
    always_comb begin
        w_rem_n = {r_srem[32:0], r_sqx[65:64]};
        w_sub   = {r_sqr[32:0], 2'b01};
    end

    logic [63:0] w_ch;
    logic        w_chpos;
    logic [63:0] w_rch;
    always_comb begin
        w_ch = r_dot < 0 ? 64'h1_0000_0000 + r_t : 64'h1_0000_0000 - r_t;
        w_chpos = (r_dot < 0) || (r_t < 64'h1_0000_0000);
        // rmin times the integer part of the change, which is 0, 1 or 2
        w_rch = w_ch[33] ? {15'd0, r_rmin, 1'b0} : (w_ch[32] ? {16'd0, r_rmin} : 64'd0);
    end

    always_comb begin
        n_st = r_st;
        w_dcmd = '0;
        w_ma = '0; w_mb = '0;
        case (r_st)
            S_IDLE: if (i_valid) n_st = w_keep ? S_MUL : (i_data.last_pair ? S_FIN : S_IDLE);
            S_MUL: begin
                case (r_k)
                    4'd0: begin w_ma = 33'(r_in.mag_a_x); w_mb = 33'(r_in.mag_a_x); end
                    4'd1: begin w_ma = 33'(r_in.mag_a_y); w_mb = 33'(r_in.mag_a_y); end
                    4'd2: begin w_ma = 33'(r_in.mag_a_z); w_mb = 33'(r_in.mag_a_z); end
                    4'd3: begin w_ma = 33'(r_in.mag_b_x); w_mb = 33'(r_in.mag_b_x); end
                    4'd4: begin w_ma = 33'(r_in.mag_b_y); w_mb = 33'(r_in.mag_b_y); end
                    4'd5: begin w_ma = 33'(r_in.mag_b_z); w_mb = 33'(r_in.mag_b_z); end
                    4'd6: begin w_ma = 33'(r_in.mag_a_x); w_mb = 33'(r_in.mag_b_x); end
                    4'd7: begin w_ma = 33'(r_in.mag_a_y); w_mb = 33'(r_in.mag_b_y); end
                    default: begin w_ma = 33'(r_in.mag_a_z); w_mb = 33'(r_in.mag_b_z); end
                endcase
                if (r_k == 4'd8) n_st = S_SQA;
            end
            S_SQA: if (r_sqi == 6'd33) n_st = S_SQB;
            S_SQB: if (r_sqi == 6'd33) n_st = S_PQ;
            S_PQ: begin
                w_ma = r_qa; w_mb = r_sqr;
                if (r_na == 0 || r_nb == 0) n_st = (r_in.last_pair ? S_FIN : S_IDLE);
                else begin
                    w_dcmd.start = 1'b1;
                    w_dcmd.steps = 7'd110;
                    w_dcmd.num = r_dot < 0 ? 64'(-r_dot) : 64'(r_dot);
                    w_dcmd.den = 64'(w_mp);
                    n_st = S_DCOS;
                end
            end
            S_DCOS: if (!w_dbusy) n_st = S_TERM;
            S_TERM: begin
                w_ma = {15'd0, r_gmr};
                w_mb = w_dq > 64'h4000_0000 ? 33'h4000_0000 : 33'(w_dq);
                n_st = S_RM;
            end
            S_RM: begin
                if (!w_chpos || r_rmin == 0) n_st = r_in.last_pair ? S_FIN : S_IDLE;
                else begin
                    w_ma = {1'b0, r_rmin[31:0]}; w_mb = {1'b0, w_ch[31:0]};
                    n_st = S_RSUM;
                end
            end
            S_RSUM: begin
                w_ma = {17'd0, r_rmin[47:32]}; w_mb = {1'b0, w_ch[31:0]};
                n_st = S_DG;
            end
            S_DG: begin
                w_dcmd.start = 1'b1;
                w_dcmd.steps = 7'd120;
                w_dcmd.num = 64'd1;
                // a resistance below one lsb counts as one lsb
                w_dcmd.den = (r_rr == 64'd0) ? 64'd1 : r_rr;
                n_st = S_ACC;
            end
            S_ACC: if (!w_dbusy) n_st = r_in.last_pair ? S_FIN : S_IDLE;
            S_FIN: begin
                if (r_cnt != 0 && r_err == 0 && r_sum != 0) begin
                    w_dcmd.start = 1'b1;
                    w_dcmd.steps = 7'd120;
                    w_dcmd.num = 64'(r_cnt);
                    w_dcmd.den = r_sum;
                    n_st = S_DRES;
                end else n_st = S_OUT;
            end
            S_DRES: if (!w_dbusy) n_st = S_OUT;
            S_OUT: if (!i_stall) n_st = S_IDLE;
            default: n_st = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= S_IDLE; r_sum <= '0; r_cnt <= '0; r_err <= '0;
        end else begin
            r_st <= n_st;
            case (r_st)
                S_IDLE: if (i_valid) begin
                    r_in <= i_data; r_k <= '0;
                    r_na <= '0; r_nb <= '0; r_dot <= '0;
                    if (w_keep) r_cnt <= r_cnt + 21'd1;
                end
                S_MUL: begin
                    r_k <= r_k + 4'd1;
                    if (r_k < 4'd3) r_na <= r_na + 50'(w_mp);
                    else if (r_k < 4'd6) r_nb <= r_nb + 50'(w_mp);
                    else r_dot <= r_dot + 50'(w_mp);
                    if (r_k == 4'd8) begin
                        r_sqx <= {r_na, 16'd0}; r_srem <= '0; r_sqr <= '0; r_sqi <= '0;
                    end
                end
                S_SQA, S_SQB: begin
                    if (r_sqi == 6'd33) begin
                        // first root done: keep it and start on the second
                        if (r_st == S_SQA) begin
                            r_qa <= r_sqr; r_sqx <= {r_nb, 16'd0};
                            r_srem <= '0; r_sqr <= '0; r_sqi <= '0;
                        end
                    end else begin
                        r_sqi <= r_sqi + 6'd1;
                        r_sqx <= r_sqx << 2;
                        if (w_rem_n >= w_sub) begin
                            r_srem <= w_rem_n - w_sub;
                            r_sqr  <= {r_sqr[31:0], 1'b1};
                        end else begin
                            r_srem <= w_rem_n;
                            r_sqr  <= {r_sqr[31:0], 1'b0};
                        end
                    end
                end
                S_PQ: if ((r_na == 0 || r_nb == 0) && r_err == 0) r_err <= StZeroV;
                S_TERM: r_t <= 64'(w_mp[65:15]);
                S_RM: begin
                    if ((!w_chpos || r_rmin == 0) && r_err == 0) r_err <= StNonPos;
                    r_rr <= 64'(w_mp);
                end
                S_RSUM: r_rr <= {32'd0, r_rr[63:32]} + 64'(w_mp) + w_rch;
                S_ACC: if (!w_dbusy) begin
                    r_sum <= (r_sum > ~w_dq) ? '1 : r_sum + w_dq;
                end
                S_FIN: begin
                    r_out.pair_count <= r_cnt;
                    r_out.resistance <= (r_cnt != 0 && r_err == 0 && r_sum == 0) ? '1 : '0;
                    r_out.status <= r_cnt == 0 ? StNoPair : r_err;
                end
                S_DRES: if (!w_dbusy) r_out.resistance <= (w_dq[63:48] != 0) ? '1 : w_dq[47:0];
                S_OUT: if (!i_stall) begin
                    r_sum <= '0; r_cnt <= '0; r_err <= '0;
                end
                default: ;
            endcase
        end
    end

    assign o_stall = (r_st != S_IDLE);
    assign o_valid = (r_st == S_OUT);
    assign o_data  = r_out;
endmodule

/* rtl/gmr_checker.sv */
// port-level checks for the accumulator, bound to the top level
module gmr_checker
    import gmr_pkg::*;
(
    input logic i_clk,
    input logic i_rst_n,
    input logic o_stall,
    input logic o_valid,
    input logic i_stall,
    input t_out o_data
);
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_data)) else $error("out beat changed");
    a_busy_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_stall) else $error("input open during result");
    a_nopair: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_data.pair_count == 0 |-> o_data.status == StNoPair)
        else $error("empty group status");
    a_err_res: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_data.status != StOk |-> o_data.resistance == 0)
        else $error("error with resistance");
endmodule

bind gmr_parallel_resistance_accumulator_unit gmr_checker u_chk (.*);
